// ===== rtl/fdmd_pkg.sv =====
// Shared types, constants and helpers for the frame difference motion detector.
`timescale 1ns / 1ps

package fdmd_pkg;

  // Frame store geometry
  localparam int MAX_PIXELS = 131072;
  localparam int ADDR_W     = $clog2(MAX_PIXELS);
  localparam int FILL_W     = $clog2(MAX_PIXELS + 1);
  localparam logic [ADDR_W-1:0] LAST_POS = ADDR_W'(MAX_PIXELS - 1);

  // Datapath widths
  localparam int CHAN_W = 8;
  localparam int CNT_W  = 18;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  // Register reset values
  localparam logic [CHAN_W-1:0] DIFF_THR_RESET  = CHAN_W'(40);
  localparam logic [CNT_W-1:0]  COUNT_THR_RESET = CNT_W'(300);

  // Configuration port
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  typedef enum logic {
    REG_DIFF_THR  = 1'b0,
    REG_COUNT_THR = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic [CHAN_W-1:0] diff_threshold;
    logic [CNT_W-1:0]  count_threshold;
  } cfg_t;

  // Input beat
  typedef struct packed {
    logic [CHAN_W-1:0] chan0;
    logic [CHAN_W-1:0] chan1;
    logic [CHAN_W-1:0] chan2;
    logic              end_of_frame;
  } pix_t;

  // Result beat
  typedef struct packed {
    logic [CHAN_W-1:0] out_chan0;
    logic [CHAN_W-1:0] out_chan1;
    logic [CHAN_W-1:0] out_chan2;
    logic              pixel_changed;
    logic              frame_done;
    logic              motion;
  } res_t;

  // Stored pixel of the previous frame
  typedef struct packed {
    logic [CHAN_W-1:0] c2;
    logic [CHAN_W-1:0] c1;
    logic [CHAN_W-1:0] c0;
  } px_t;

  // Write request into the frame store
  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    px_t               data;
  } store_wr_t;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

endpackage

// ===== rtl/fdmd_cfg.sv =====
// APB register file holding the two detection thresholds.
`timescale 1ns / 1ps

module fdmd_cfg (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [fdmd_pkg::PDATA_W-1:0]  pwdata,
  output logic [fdmd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready,
  output fdmd_pkg::cfg_t                cfg
);

  logic                 wr_en;
  fdmd_pkg::reg_idx_t   sel;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign sel    = fdmd_pkg::reg_idx_t'(paddr[fdmd_pkg::PADDR_W-1]);

  // Register writes; bits above each register are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_threshold  <= fdmd_pkg::DIFF_THR_RESET;
      cfg.count_threshold <= fdmd_pkg::COUNT_THR_RESET;
    end else if (wr_en) begin
      unique case (sel)
        fdmd_pkg::REG_DIFF_THR: begin
          cfg.diff_threshold <= pwdata[fdmd_pkg::CHAN_W-1:0];
        end
        fdmd_pkg::REG_COUNT_THR: begin
          cfg.count_threshold <= pwdata[fdmd_pkg::CNT_W-1:0];
        end
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (sel)
      fdmd_pkg::REG_DIFF_THR:  prdata = fdmd_pkg::PDATA_W'(cfg.diff_threshold);
      fdmd_pkg::REG_COUNT_THR: prdata = fdmd_pkg::PDATA_W'(cfg.count_threshold);
    endcase
  end

endmodule

// ===== rtl/fdmd_store.sv =====
// Previous-frame store: single-port-write RAM with fill count and write bypass.
`timescale 1ns / 1ps

module fdmd_store (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         rd_en,
  input  logic [fdmd_pkg::ADDR_W-1:0]  rd_addr,
  input  fdmd_pkg::store_wr_t          wr,
  output fdmd_pkg::px_t                rd_data
);

  fdmd_pkg::px_t               mem [fdmd_pkg::MAX_PIXELS];
  fdmd_pkg::px_t               mem_q;
  fdmd_pkg::px_t               byp_data;
  logic                        byp;
  logic                        rd_ok;
  logic [fdmd_pkg::FILL_W-1:0] fill;

  // RAM array, read data registered
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    if (rd_en) begin
      mem_q <= mem[rd_addr];
    end
  end

  // Entries are written as a growing prefix from address zero, so the
  // high-water mark tells which ones have not been written yet and read as zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (wr.en && (fdmd_pkg::FILL_W'(wr.addr) == fill)) begin
      fill <= fill + fdmd_pkg::FILL_W'(1);
    end
  end

  // Catch a write landing on the address read in the same cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp   <= 1'b0;
      rd_ok <= 1'b0;
    end else if (rd_en) begin
      byp   <= wr.en && (wr.addr == rd_addr);
      rd_ok <= fdmd_pkg::FILL_W'(rd_addr) < fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      byp_data <= wr.data;
    end
  end

  assign rd_data = byp ? byp_data : (rd_ok ? mem_q : '0);

endmodule

// ===== rtl/fdmd_pixel.sv =====
// Compare stage: channel differences, changed count, motion flag, result register.
`timescale 1ns / 1ps

module fdmd_pixel (
  input  logic                         clk,
  input  logic                         rst,
  input  fdmd_pkg::cfg_t               cfg,
  input  logic                         s1_valid,
  input  fdmd_pkg::pix_t               s1_pix,
  input  logic [fdmd_pkg::ADDR_W-1:0]  s1_pos,
  input  fdmd_pkg::px_t                prev,
  output logic                         s1_adv,
  output fdmd_pkg::store_wr_t          wr,
  output logic                         res_valid,
  input  logic                         res_ready,
  output fdmd_pkg::res_t               res
);

  logic                       changed;
  logic [fdmd_pkg::CNT_W-1:0] changed_count;
  logic [fdmd_pkg::CNT_W-1:0] cnt_inc;
  logic [fdmd_pkg::CNT_W-1:0] changed_count_next;
  fdmd_pkg::res_t             res_next;

  // All three channels must move by more than the threshold
  assign changed =
    (fdmd_pkg::abs_diff(s1_pix.chan0, prev.c0) > cfg.diff_threshold) &&
    (fdmd_pkg::abs_diff(s1_pix.chan1, prev.c1) > cfg.diff_threshold) &&
    (fdmd_pkg::abs_diff(s1_pix.chan2, prev.c2) > cfg.diff_threshold);

  // Saturating count, cleared after the last pixel of a frame
  always_comb begin
    cnt_inc = (changed && (changed_count != fdmd_pkg::COUNT_MAX))
              ? changed_count + fdmd_pkg::CNT_W'(1) : changed_count;
    changed_count_next = s1_pix.end_of_frame ? '0 : cnt_inc;
  end

  // Result beat
  always_comb begin
    res_next.out_chan0     = changed ? s1_pix.chan0 : '0;
    res_next.out_chan1     = changed ? s1_pix.chan1 : '0;
    res_next.out_chan2     = changed ? s1_pix.chan2 : '0;
    res_next.pixel_changed = changed;
    res_next.frame_done    = s1_pix.end_of_frame;
    res_next.motion        = s1_pix.end_of_frame && (cnt_inc > cfg.count_threshold);
  end

  // Advance when the result register is free or being drained
  assign s1_adv = s1_valid && (!res_valid || res_ready);

  // New pixel replaces the stored one
  assign wr.en   = s1_adv;
  assign wr.addr = s1_pos;
  assign wr.data = '{c2: s1_pix.chan2, c1: s1_pix.chan1, c0: s1_pix.chan0};

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid     <= 1'b0;
      changed_count <= '0;
    end else begin
      if (s1_adv) begin
        res_valid     <= 1'b1;
        changed_count <= changed_count_next;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res <= res_next;
    end
  end

endmodule

// ===== rtl/frame_difference_motion_detector.sv =====
// Top level of the frame difference motion detector.
//
// Pixels enter on the pix channel (valid/ready), one beat per pixel in raster
// order, end_of_frame set on the last pixel of each frame. Each pixel gives
// exactly one beat on the res channel: the pixel itself when all three
// channels differ from the stored previous-frame pixel by more than
// diff_threshold, black otherwise, plus the changed flag. On the last pixel
// frame_done is set and motion reports whether the frame's changed count
// exceeded count_threshold.
// res_valid is driven by the result register, which is loaded from the
// input register; one pixel is taken every cycle as long as the receiver
// keeps res_ready high, the limit being the one read and one write
// of the frame RAM per pixel. The RAM read is issued on acceptance and the
// compare stage writes the new pixel back as it hands its result on.
// Reset clears the position, count and fill count; the frame RAM needs no
// clearing pass, entries at or above the fill count read as black, so
// pixels are accepted right after reset. Thresholds reset to 40 and 300 and
// the user must write them over the APB port only while the block is idle; the block does not enforce it.
// When the receiver stalls, the result register holds and pix_ready drops
// once the compare stage is also occupied.
`timescale 1ns / 1ps

module frame_difference_motion_detector (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          pix_valid,
  output logic                          pix_ready,
  input  fdmd_pkg::pix_t                pix,
  output logic                          res_valid,
  input  logic                          res_ready,
  output fdmd_pkg::res_t                res,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdmd_pkg::PADDR_W-1:0]  paddr,
  input  logic [fdmd_pkg::PDATA_W-1:0]  pwdata,
  output logic [fdmd_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  fdmd_pkg::cfg_t              cfg;
  fdmd_pkg::store_wr_t         wr;
  fdmd_pkg::px_t               prev;
  fdmd_pkg::pix_t              s1_pix;
  logic                        s1_valid;
  logic                        s1_adv;
  logic [fdmd_pkg::ADDR_W-1:0] s1_pos;
  logic [fdmd_pkg::ADDR_W-1:0] pos;
  logic [fdmd_pkg::ADDR_W-1:0] pos_next;
  logic                        accept;

  fdmd_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Input stage
  assign pix_ready = !s1_valid || s1_adv;
  assign accept    = pix_valid && pix_ready;

  // Position wraps at the store depth and restarts after end of frame
  always_comb begin
    if (pix.end_of_frame || (pos == fdmd_pkg::LAST_POS)) begin
      pos_next = '0;
    end else begin
      pos_next = pos + fdmd_pkg::ADDR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      pos      <= '0;
    end else begin
      if (accept) begin
        s1_valid <= 1'b1;
        pos      <= pos_next;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix <= pix;
      s1_pos <= pos;
    end
  end

  fdmd_store u_store (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (accept),
    .rd_addr (pos),
    .wr      (wr),
    .rd_data (prev)
  );

  fdmd_pixel u_pixel (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .s1_valid  (s1_valid),
    .s1_pix    (s1_pix),
    .s1_pos    (s1_pos),
    .prev      (prev),
    .s1_adv    (s1_adv),
    .wr        (wr),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  // Motion is only ever reported on the last pixel of a frame
  a_motion_eof: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.motion |-> res.frame_done)
    else $error("motion without frame_done");

  // Unchanged pixels come out black
  a_black: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.pixel_changed |->
      (res.out_chan0 == '0) && (res.out_chan1 == '0) && (res.out_chan2 == '0))
    else $error("unchanged pixel not black");

  // A stalled result is never overwritten by the compare stage
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |-> !s1_adv)
    else $error("result register overwritten while stalled");

  // The frame RAM is written only by a beat leaving the compare stage
  a_wr_src: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> s1_valid && (wr.addr == s1_pos))
    else $error("store write without a pixel in the compare stage");

endmodule
